### sv/annexb_pkg.sv
// annexb_pkg: shared types, codes and constants of the annex b splitter
// used by annexb_parser, annexb_out_seq and annexb_nal_unit_splitter
`timescale 1ns / 1ps

package annexb_pkg;

  // widths of the result fields
  localparam int KIND_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int UTYPE_W    = 5;
  localparam int UNIT_OFF_W = 32;
  localparam int ERR_W      = 2;

  // default width of the running byte position
  localparam int OFFSET_BITS_DEF = 32;

  // at most this many results come out of one input beat
  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECORD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_PRE_START = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SVC_FLAG  = 2'd2;

  // special byte values and unit types
  localparam logic [BYTE_W-1:0]  BYTE_ZERO     = 8'h00;
  localparam logic [BYTE_W-1:0]  BYTE_SC       = 8'h01;
  localparam logic [BYTE_W-1:0]  BYTE_EPB      = 8'h03;
  localparam logic [UTYPE_W-1:0] TYPE_PREFIX   = 5'd14;
  localparam logic [UTYPE_W-1:0] TYPE_EXT_SLC  = 5'd20;
  localparam logic [UTYPE_W-1:0] TYPE_UNSPEC   = 5'd0;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [BYTE_W-1:0]     pbyte;
    logic [UTYPE_W-1:0]    utype;
    logic [UNIT_OFF_W-1:0] offset;
    logic [ERR_W-1:0]      err;
  } res_t;

  // all results of one input beat, in order, plus their count
  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]   cnt;
  } bundle_t;

endpackage

### sv/annexb_nal_unit_splitter.sv
// annexb_nal_unit_splitter: h.264 annex b byte stream splitter, top level
// an accepted beat's results go to the bundle register, then one by one to the output register
// throughput: 1 byte per cycle while out_stall is low and each byte yields at most one result;
//   a byte with more results (up to 4) holds the input until the single output register
//   has drained the result bundle, one beat a cycle while out_stall is low
// reset: synchronous active-low rst_n clears parse state, position and both result stages
`timescale 1ns / 1ps

module annexb_nal_unit_splitter import annexb_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_stream_byte,
  input  logic                  in_end_of_stream,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KIND_W-1:0]     out_result_kind,
  output logic [BYTE_W-1:0]     out_payload_byte,
  output logic [UTYPE_W-1:0]    out_unit_type,
  output logic [UNIT_OFF_W-1:0] out_unit_offset,
  output logic [ERR_W-1:0]      out_error_code,
  output logic                  out_last_result
);

  logic    accept;
  logic    room;
  bundle_t bundle;

  // a beat enters whenever the bundle register has room for its results
  assign in_stall = !room;
  assign accept   = in_valid && room;

  // parse stage: state registers plus the per-byte search / header / unescape logic,
  // producing every result of the byte at once
  annexb_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .stream_byte   (in_stream_byte),
    .end_of_stream (in_end_of_stream),
    .bundle        (bundle)
  );

  // result stage: bundle register, then the output register that faces the consumer
  annexb_out_seq u_out_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (accept),
    .bundle           (bundle),
    .room             (room),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_unit_type    (out_unit_type),
    .out_unit_offset  (out_unit_offset),
    .out_error_code   (out_error_code),
    .out_last_result  (out_last_result)
  );

  // input only backs up when results are pending, so output turns valid next cycle
  a_stall_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> out_valid)
    else $error("input stalled with no result on its way out");

  // records never carry the unspecified type
  a_record_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_RECORD) |-> out_unit_type != TYPE_UNSPEC)
    else $error("record beat with unit type zero");

  // error beats carry a code, other beats carry none
  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result_kind == KIND_ERROR) == (out_error_code != ERR_NONE)))
    else $error("error code does not match result kind");

endmodule

### sv/annexb_parser.sv
// annexb_parser: start code search, header and escape handling for one byte a beat
// holds the parse state; builds the result bundle of each byte; uses annexb_pkg
`timescale 1ns / 1ps

module annexb_parser import annexb_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] stream_byte,
  input  logic              end_of_stream,
  output bundle_t           bundle
);

  localparam logic [2:0] PH_SEARCH  = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;

  logic [2:0]             phase_r, phase_nxt;
  logic [1:0]             held_r, held_nxt;
  logic [1:0]             left_r, left_nxt;
  logic [UTYPE_W-1:0]     type_r, type_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;

  logic [UNIT_OFF_W-1:0]  pos_w, off_w, rec_off;
  logic                   unit_open;
  logic [CNT_W-1:0]       n;
  bundle_t                bnd;

  function automatic res_t mk_res(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] pb,
                                  logic [UTYPE_W-1:0] ty, logic [UNIT_OFF_W-1:0] off,
                                  logic [ERR_W-1:0] err);
    res_t r;
    r.kind   = kind;
    r.pbyte  = pb;
    r.utype  = ty;
    r.offset = off;
    r.err    = err;
    return r;
  endfunction

  // record offsets carry the position, cut to its low bits or zero-extended to the field width
  generate
    if (OFFSET_BITS >= UNIT_OFF_W) begin : g_trunc
      assign pos_w = pos_r[UNIT_OFF_W-1:0];
      assign off_w = off_r[UNIT_OFF_W-1:0];
    end else begin : g_ext
      assign pos_w = {{(UNIT_OFF_W-OFFSET_BITS){1'b0}}, pos_r};
      assign off_w = {{(UNIT_OFF_W-OFFSET_BITS){1'b0}}, off_r};
    end
  endgenerate

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    left_nxt  = left_r;
    type_nxt  = type_r;
    off_nxt   = off_r;
    pos_nxt   = pos_r + OFFSET_BITS'(1);
    rec_off   = off_w;
    unit_open = 1'b0;
    n         = '0;
    bnd       = '0;

    case (phase_r)
      PH_SEARCH: begin
        if (stream_byte == BYTE_ZERO) begin
          if (held_r < 2'd2) held_nxt = held_r + 2'd1;
        end else if (stream_byte == BYTE_SC && held_r >= 2'd2) begin
          held_nxt  = 2'd0;
          phase_nxt = PH_HEADER;
        end else begin
          held_nxt = 2'd0;
          bnd.ent[n[IDX_W-1:0]] = mk_res(KIND_ERROR, '0, '0, '0, ERR_PRE_START);
          n = n + CNT_W'(1);
        end
      end
      PH_HEADER: begin
        type_nxt  = stream_byte[UTYPE_W-1:0];
        off_nxt   = pos_r;
        rec_off   = pos_w;
        held_nxt  = 2'd0;
        unit_open = 1'b1;
        if (type_nxt == TYPE_PREFIX || type_nxt == TYPE_EXT_SLC) begin
          phase_nxt = PH_EXT;
          left_nxt  = 2'd3;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_EXT: begin
        unit_open = 1'b1;
        if (left_r == 2'd3 && !stream_byte[BYTE_W-1]) begin
          bnd.ent[n[IDX_W-1:0]] = mk_res(KIND_ERROR, '0, '0, '0, ERR_SVC_FLAG);
          n = n + CNT_W'(1);
        end
        if (left_r != 2'd0) left_nxt = left_r - 2'd1;
        if (left_nxt == 2'd0) phase_nxt = PH_PAYLOAD;
      end
      default: begin
        phase_nxt = PH_PAYLOAD;
        unit_open = 1'b1;
        if (stream_byte == BYTE_ZERO && held_r < 2'd2) begin
          held_nxt = held_r + 2'd1;
        end else if (held_r >= 2'd2 && stream_byte == BYTE_ZERO) begin
          // third zero: trailing zeros, unit closes
          if (type_r != TYPE_UNSPEC) begin
            bnd.ent[n[IDX_W-1:0]] = mk_res(KIND_RECORD, '0, type_r, off_w, ERR_NONE);
            n = n + CNT_W'(1);
          end
          held_nxt  = 2'd2;
          phase_nxt = PH_SEARCH;
          unit_open = 1'b0;
        end else if (held_r >= 2'd2 && stream_byte == BYTE_SC) begin
          if (type_r != TYPE_UNSPEC) begin
            bnd.ent[n[IDX_W-1:0]] = mk_res(KIND_RECORD, '0, type_r, off_w, ERR_NONE);
            n = n + CNT_W'(1);
          end
          held_nxt  = 2'd0;
          phase_nxt = PH_HEADER;
          unit_open = 1'b0;
        end else if (held_r >= 2'd2 && stream_byte == BYTE_EPB) begin
          // emulation prevention: keep the zeros, drop the 03
          for (int i = 0; i < 2; i++) begin
            bnd.ent[n[IDX_W-1:0]] = mk_res(KIND_PAYLOAD, '0, '0, '0, ERR_NONE);
            n = n + CNT_W'(1);
          end
          held_nxt = 2'd0;
        end else begin
          for (int i = 0; i < 2; i++) begin
            if (2'(i) < held_r) begin
              bnd.ent[n[IDX_W-1:0]] = mk_res(KIND_PAYLOAD, '0, '0, '0, ERR_NONE);
              n = n + CNT_W'(1);
            end
          end
          held_nxt = 2'd0;
          bnd.ent[n[IDX_W-1:0]] = mk_res(KIND_PAYLOAD, stream_byte, '0, '0, ERR_NONE);
          n = n + CNT_W'(1);
        end
      end
    endcase

    if (end_of_stream) begin
      // flush held zeros and the open unit's record, then back to reset
      if (unit_open) begin
        for (int i = 0; i < 2; i++) begin
          if (2'(i) < held_nxt) begin
            bnd.ent[n[IDX_W-1:0]] = mk_res(KIND_PAYLOAD, '0, '0, '0, ERR_NONE);
            n = n + CNT_W'(1);
          end
        end
        if (type_nxt != TYPE_UNSPEC) begin
          bnd.ent[n[IDX_W-1:0]] = mk_res(KIND_RECORD, '0, type_nxt, rec_off, ERR_NONE);
          n = n + CNT_W'(1);
        end
      end
      phase_nxt = PH_SEARCH;
      held_nxt  = 2'd0;
      left_nxt  = 2'd0;
      type_nxt  = '0;
      off_nxt   = '0;
      pos_nxt   = '0;
    end

    bnd.cnt = n;
  end

  assign bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      held_r  <= 2'd0;
      left_r  <= 2'd0;
      type_r  <= '0;
      off_r   <= '0;
      pos_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      left_r  <= left_nxt;
      type_r  <= type_nxt;
      off_r   <= off_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

### sv/annexb_out_seq.sv
// annexb_out_seq: result bundle register drained one beat a cycle, unless stalled, into the output register
// uses annexb_pkg types
`timescale 1ns / 1ps

module annexb_out_seq import annexb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  bundle_t               bundle,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KIND_W-1:0]     out_result_kind,
  output logic [BYTE_W-1:0]     out_payload_byte,
  output logic [UTYPE_W-1:0]    out_unit_type,
  output logic [UNIT_OFF_W-1:0] out_unit_offset,
  output logic [ERR_W-1:0]      out_error_code,
  output logic                  out_last_result
);

  res_t [MAX_RES-1:0] ent_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   idx_r;
  logic               ov_r;
  res_t               ores_r;
  logic               olast_r;

  logic oreg_free, move;

  assign oreg_free = !ov_r || !out_stall;
  assign move      = (cnt_r != '0) && oreg_free;
  // bundle can take a new beat when empty or once its last result leaves this cycle
  assign room      = (cnt_r == '0) || (cnt_r == CNT_W'(1) && oreg_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= bundle.cnt;
      idx_r <= '0;
    end else if (move) begin
      cnt_r <= cnt_r - CNT_W'(1);
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) ent_r <= bundle.ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (move) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      ores_r  <= ent_r[idx_r];
      olast_r <= (cnt_r == CNT_W'(1));
    end
  end

  assign out_valid        = ov_r;
  assign out_result_kind  = ores_r.kind;
  assign out_payload_byte = ores_r.pbyte;
  assign out_unit_type    = ores_r.utype;
  assign out_unit_offset  = ores_r.offset;
  assign out_error_code   = ores_r.err;
  assign out_last_result  = olast_r;

endmodule
